// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define FEFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fefc assertion failed");

// Clocked assertion that also runs during reset.
`define FEFC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fefc reset assertion failed");

`endif

// ----- hdl/fefc_pkg.sv -----
`timescale 1ns / 1ps

package fefc_pkg;

    localparam int TAPS           = 17;
    localparam int SAMPLE_BITS    = 10;
    localparam int COEF_BITS      = 16;
    localparam int OUT_SHIFT      = 17;
    localparam int DAC_BITS       = 8;
    localparam int OP_BITS        = 2;
    localparam int SAMPLE_IN_BITS = 10;
    localparam int SEL_IDX_BITS   = 5;
    localparam int SEL_VAL_BITS   = 16;

    localparam int IDX_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;
    localparam int SUM_W  = PROD_W + $clog2(TAPS);
    localparam int ACC_W  = (SUM_W > OUT_SHIFT + DAC_BITS) ? SUM_W : OUT_SHIFT + DAC_BITS;

    localparam int DEFAULT_COUNT = 17;
    localparam int DEFAULT_COEFS [DEFAULT_COUNT] = '{
        -248, 665, 940, -190, -2027, -1580, 3123, 9688, 12808,
        9688, 3123, -1580, -2027, -190, 940, 665, -248
    };

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [COEF_BITS-1:0]     t_coef;
    typedef logic [SAMPLE_BITS-1:0]   t_sample;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [OP_BITS-1:0] {
        OP_SAMPLE = 2'd0,
        OP_SELECT = 2'd1,
        OP_INC    = 2'd2,
        OP_DEC    = 2'd3
    } t_op;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    function automatic t_coef default_coef(input t_idx idx);
        logic [31:0] w;
        w = '0;
        if (32'(idx) < DEFAULT_COUNT) begin
            w = 32'(DEFAULT_COEFS[idx]);
        end
        return w[COEF_BITS-1:0];
    endfunction

    function automatic t_idx idx_next(input t_idx idx);
        return (idx == IDX_W'(TAPS - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic t_idx idx_prev(input t_idx idx);
        return (idx == '0) ? IDX_W'(TAPS - 1) : idx - IDX_W'(1);
    endfunction

    function automatic t_sample to_sample(input logic [SAMPLE_IN_BITS-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SEL_VAL_BITS-1:0] to_sel_value(input t_coef c);
        logic [31:0] w;
        w = 32'(c);
        return w[SEL_VAL_BITS-1:0];
    endfunction

    function automatic logic [SEL_IDX_BITS-1:0] to_sel_index(input t_idx idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[SEL_IDX_BITS-1:0];
    endfunction

endpackage

// ----- hdl/fefc_mac.sv -----
`timescale 1ns / 1ps

module fefc_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fefc_pkg::t_mac_ctl  i_ctl,
    input  fefc_pkg::t_coef     i_coef,
    input  fefc_pkg::t_sample   i_sample,
    output fefc_pkg::t_acc      o_acc,
    output logic                o_busy
);

    fefc_pkg::t_prod r_prod;
    logic            r_prod_vld;
    fefc_pkg::t_acc  r_acc;
    fefc_pkg::t_prod n_prod;

    assign n_prod = fefc_pkg::PROD_W'(signed'(i_coef))
                  * fefc_pkg::PROD_W'(signed'({1'b0, i_sample}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + fefc_pkg::ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

// ----- hdl/fir_filter_editable_coefficients_top.sv -----
`timescale 1ns / 1ps

// 17-tap FIR filter with coefficients edited at run time. Items are taken one
// at a time. A sample item writes the ring and then runs one shared multiplier
// over the taps, one tap per cycle from the coefficient and sample memories,
// and no new item is accepted until the last one is done. A finished result
// sits in the output register while the next item is accepted and waits
// only if that register is still full. Every item returns the last DAC
// code, the selected coefficient index and its current value.
module fir_filter_editable_coefficients_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [fefc_pkg::OP_BITS-1:0]             i_operation,
    input  logic [fefc_pkg::SAMPLE_IN_BITS-1:0]      i_sample_in,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [fefc_pkg::DAC_BITS-1:0]            o_dac_code,
    output logic [fefc_pkg::SEL_IDX_BITS-1:0]        o_selected_index,
    output logic signed [fefc_pkg::SEL_VAL_BITS-1:0] o_selected_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_SEL_RD,
        S_SEL_WAIT
    } t_state;

    t_state                             r_state;
    fefc_pkg::t_op                      r_op;
    fefc_pkg::t_idx                     r_wp;
    fefc_pkg::t_idx                     r_edit;
    fefc_pkg::t_idx                     r_ridx;
    fefc_pkg::t_cnt                     r_tap;
    logic [fefc_pkg::DAC_BITS-1:0]      r_last_dac;
    logic                               r_rd_vld;

    logic                               r_out_valid;
    logic [fefc_pkg::DAC_BITS-1:0]      r_out_dac;
    logic [fefc_pkg::SEL_IDX_BITS-1:0]  r_out_idx;
    logic [fefc_pkg::SEL_VAL_BITS-1:0]  r_out_val;

    fefc_pkg::t_coef                    r_coef_mem [fefc_pkg::TAPS];
    logic [fefc_pkg::TAPS-1:0]          r_coef_vld;
    fefc_pkg::t_coef                    r_coef_rd;
    fefc_pkg::t_coef                    r_coef_dflt;
    logic                               r_coef_rd_ok;

    fefc_pkg::t_sample                  r_ring_mem [fefc_pkg::TAPS];
    logic [fefc_pkg::TAPS-1:0]          r_ring_vld;
    fefc_pkg::t_sample                  r_ring_rd;
    logic                               r_ring_rd_ok;

    logic                               accept;
    logic                               issue;
    logic                               out_free;
    logic                               out_load;
    logic                               coef_re;
    logic                               coef_we;
    fefc_pkg::t_idx                     coef_raddr;
    logic                               ring_we;
    fefc_pkg::t_coef                    coef_eff;
    fefc_pkg::t_sample                  ring_eff;
    fefc_pkg::t_coef                    n_coef;
    logic [fefc_pkg::DAC_BITS-1:0]      n_dac;
    fefc_pkg::t_mac_ctl                 mac_ctl;
    fefc_pkg::t_acc                     mac_acc;
    logic                               mac_busy;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign out_load = (r_state == S_SEL_WAIT) && out_free;
    assign issue    = (r_state == S_MAC) && (r_tap != fefc_pkg::CNT_W'(fefc_pkg::TAPS));

    assign coef_re    = issue || (r_state == S_SEL_RD);
    assign coef_raddr = issue ? r_tap[fefc_pkg::IDX_W-1:0] : r_edit;
    assign coef_we    = (r_state == S_SEL_WAIT) && out_free
                     && ((r_op == fefc_pkg::OP_INC) || (r_op == fefc_pkg::OP_DEC));
    assign ring_we    = accept && (fefc_pkg::t_op'(i_operation) == fefc_pkg::OP_SAMPLE);

    assign coef_eff = r_coef_rd_ok ? r_coef_rd : r_coef_dflt;
    assign ring_eff = r_ring_rd_ok ? r_ring_rd : '0;

    always_comb begin
        unique case (r_op)
            fefc_pkg::OP_INC: n_coef = coef_eff + fefc_pkg::COEF_BITS'(1);
            fefc_pkg::OP_DEC: n_coef = coef_eff - fefc_pkg::COEF_BITS'(1);
            default:          n_coef = coef_eff;
        endcase
    end

    assign n_dac = mac_acc[fefc_pkg::OUT_SHIFT +: fefc_pkg::DAC_BITS]
                 - fefc_pkg::DAC_BITS'(1);

    assign mac_ctl.clear = ring_we;
    assign mac_ctl.valid = r_rd_vld;

    fefc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_coef   (coef_eff),
        .i_sample (ring_eff),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    // coefficient memory; unwritten entries read as the default table
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[r_edit] <= n_coef;
        end
        if (coef_re) begin
            r_coef_rd   <= r_coef_mem[coef_raddr];
            r_coef_dflt <= fefc_pkg::default_coef(coef_raddr);
        end
    end

    // sample ring; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[r_wp] <= fefc_pkg::to_sample(i_sample_in);
        end
        if (issue) begin
            r_ring_rd <= r_ring_mem[r_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld   <= '0;
            r_coef_rd_ok <= 1'b0;
            r_ring_vld   <= '0;
            r_ring_rd_ok <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (coef_we) begin
                r_coef_vld[r_edit] <= 1'b1;
            end
            if (coef_re) begin
                r_coef_rd_ok <= r_coef_vld[coef_raddr];
            end
            if (ring_we) begin
                r_ring_vld[r_wp] <= 1'b1;
            end
            if (issue) begin
                r_ring_rd_ok <= r_ring_vld[r_ridx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= fefc_pkg::OP_SAMPLE;
            r_wp        <= '0;
            r_edit      <= '0;
            r_ridx      <= '0;
            r_tap       <= '0;
            r_last_dac  <= '0;
            r_out_valid <= 1'b0;
            r_out_dac   <= '0;
            r_out_idx   <= '0;
            r_out_val   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op <= fefc_pkg::t_op'(i_operation);
                        if (ring_we) begin
                            r_tap   <= '0;
                            r_ridx  <= r_wp;
                            r_wp    <= fefc_pkg::idx_next(r_wp);
                            r_state <= S_MAC;
                        end else begin
                            if (fefc_pkg::t_op'(i_operation) == fefc_pkg::OP_SELECT) begin
                                r_edit <= fefc_pkg::idx_next(r_edit);
                            end
                            r_state <= S_SEL_RD;
                        end
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        r_tap  <= r_tap + fefc_pkg::CNT_W'(1);
                        r_ridx <= fefc_pkg::idx_prev(r_ridx);
                    end else if (!r_rd_vld && !mac_busy) begin
                        r_last_dac <= n_dac;
                        r_state    <= S_SEL_RD;
                    end
                end
                S_SEL_RD: begin
                    r_state <= S_SEL_WAIT;
                end
                S_SEL_WAIT: begin
                    if (out_free) begin
                        r_out_dac   <= r_last_dac;
                        r_out_idx   <= fefc_pkg::to_sel_index(r_edit);
                        r_out_val   <= fefc_pkg::to_sel_value(n_coef);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_dac_code       = r_out_dac;
    assign o_selected_index = r_out_idx;
    assign o_selected_value = signed'(r_out_val);

endmodule

// ----- hdl/fefc_checker.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fefc_checker (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_valid,
    input logic                                     o_ready,
    input logic [fefc_pkg::OP_BITS-1:0]             i_operation,
    input logic [fefc_pkg::SAMPLE_IN_BITS-1:0]      i_sample_in,
    input logic                                     o_valid,
    input logic                                     i_ready,
    input logic [fefc_pkg::DAC_BITS-1:0]            o_dac_code,
    input logic [fefc_pkg::SEL_IDX_BITS-1:0]        o_selected_index,
    input logic signed [fefc_pkg::SEL_VAL_BITS-1:0] o_selected_value
);

    `FEFC_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid)
    `FEFC_ASSERT(a_one_at_a_time, i_valid && o_ready |=> !o_ready)
    `FEFC_ASSERT(a_no_instant_result, i_valid && o_ready && !o_valid |=> !o_valid)
    `FEFC_ASSERT(a_index_range, o_valid |-> 32'(o_selected_index) < fefc_pkg::TAPS)
    `FEFC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid && o_ready)

endmodule

bind fir_filter_editable_coefficients_top fefc_checker u_fefc_checker (.*);

// ----- sim/fir_filter_editable_coefficients_top_tb.sv -----
`timescale 1ns / 1ps

module fir_filter_editable_coefficients_top_tb;

    localparam int NTAPS      = 17;
    localparam int RAND_ITEMS = 450;

    localparam logic signed [15:0] RESET_COEFS [NTAPS] = '{
        -16'sd248, 16'sd665, 16'sd940, -16'sd190, -16'sd2027, -16'sd1580, 16'sd3123,
        16'sd9688, 16'sd12808, 16'sd9688, 16'sd3123, -16'sd1580, -16'sd2027,
        -16'sd190, 16'sd940, 16'sd665, -16'sd248
    };

    typedef struct {
        fefc_pkg::t_op op;
        logic [9:0]    sample;
        bit            drain;
        bit            hurry;
    } t_filter_item;

    typedef struct {
        logic [7:0]  dac_code;
        logic [4:0]  sel_index;
        logic [15:0] sel_value;
    } t_dac_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_operation = fefc_pkg::OP_SAMPLE;
    logic [9:0]  i_sample_in = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_dac_code;
    logic [4:0]  o_selected_index;
    logic signed [15:0] o_selected_value;

    fir_filter_editable_coefficients_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_sample_in      (i_sample_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_dac_code       (o_dac_code),
        .o_selected_index (o_selected_index),
        .o_selected_value (o_selected_value)
    );

    always #5 i_clk = ~i_clk;

    // filter model state
    logic signed [15:0] coef_model [NTAPS];
    logic [9:0]         sample_hist [NTAPS];
    int                 wr_ptr;
    int                 edit_sel;
    logic [7:0]         last_code;

    t_filter_item pending_items[$];
    t_dac_result  expected_outputs[$];

    int errors;
    int samples_sent;
    int edits_sent;
    int results_checked;
    int burst_left;
    int gap_left;
    logic [31:0] ready_pat;
    logic [4:0]  ready_phase;

    task automatic filter_step(input fefc_pkg::t_op op, input logic [9:0] smp);
        logic signed [63:0] acc;
        logic signed [63:0] shifted;
        t_dac_result res;
        int k;
        int j;
        case (op)
            fefc_pkg::OP_SAMPLE: begin
                sample_hist[wr_ptr] = smp;
                acc = '0;
                for (k = 0; k < NTAPS; k++) begin
                    j = (wr_ptr + NTAPS - k) % NTAPS;
                    acc += $signed(coef_model[k]) * $signed({1'b0, sample_hist[j]});
                end
                shifted = acc >>> 17;
                last_code = shifted[7:0] - 8'd1;
                wr_ptr = (wr_ptr + 1) % NTAPS;
            end
            fefc_pkg::OP_SELECT: begin
                edit_sel = (edit_sel + 1) % NTAPS;
            end
            fefc_pkg::OP_INC: begin
                coef_model[edit_sel] = coef_model[edit_sel] + 16'sd1;
            end
            default: begin
                coef_model[edit_sel] = coef_model[edit_sel] - 16'sd1;
            end
        endcase
        if (op == fefc_pkg::OP_SAMPLE) begin
            samples_sent++;
        end else begin
            edits_sent++;
        end
        res.dac_code  = last_code;
        res.sel_index = 5'(edit_sel);
        res.sel_value = coef_model[edit_sel];
        expected_outputs.push_back(res);
    endtask

    function automatic void add_item(input fefc_pkg::t_op op, input logic [9:0] smp,
                                     input bit drain, input bit hurry);
        t_filter_item it;
        it.op     = op;
        it.sample = smp;
        it.drain  = drain;
        it.hurry  = hurry;
        pending_items.push_back(it);
    endfunction

    // sender: bursts with random gaps
    always @(posedge i_clk) begin : sender
        t_filter_item it;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_valid && o_ready) begin
                filter_step(fefc_pkg::t_op'(i_operation), i_sample_in);
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_left > 0 && !pending_items[0].hurry) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_items[0].drain && expected_outputs.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    it = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= it.op;
                    i_sample_in <= it.sample;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: ready follows the bits of a random 32-bit pattern in turn, redrawn each time the phase counter wraps
    always @(posedge i_clk) begin : receiver
        logic [31:0] pat;
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            ready_phase <= '0;
            ready_pat   <= '1;
        end else begin
            pat = ready_pat;
            if (ready_phase == 0) begin
                pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
            end
            ready_pat   <= pat;
            i_ready     <= pat[ready_phase];
            ready_phase <= ready_phase + 5'd1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_dac_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outputs.size() == 0) begin
                if (errors < 10) begin
                    $display("unexpected result: dac %0d idx %0d val %0d",
                             o_dac_code, o_selected_index, o_selected_value);
                end
                errors++;
            end else begin
                want = expected_outputs.pop_front();
                results_checked++;
                if (o_dac_code !== want.dac_code || o_selected_index !== want.sel_index ||
                    o_selected_value !== want.sel_value) begin
                    if (errors < 10) begin
                        $display("result %0d: exp dac %0d idx %0d val %0d, got %0d %0d %0d",
                                 results_checked, want.dac_code, want.sel_index,
                                 $signed(want.sel_value), o_dac_code, o_selected_index,
                                 o_selected_value);
                    end
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("fir_filter_editable_coefficients_top test failed");
        $finish;
    end

    initial begin
        int n;
        int r;
        fefc_pkg::t_op op;
        logic [9:0] smp;

        errors          = 0;
        samples_sent    = 0;
        edits_sent      = 0;
        results_checked = 0;
        for (n = 0; n < NTAPS; n++) begin
            coef_model[n]  = RESET_COEFS[n];
            sample_hist[n] = '0;
        end
        wr_ptr    = 0;
        edit_sel  = 0;
        last_code = '0;

        // directed: extremes, negative sum, every op, index wrap
        add_item(fefc_pkg::OP_SAMPLE, 10'h3FF, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_SAMPLE, 10'h000, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_SAMPLE, 10'h155, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_SAMPLE, 10'h2AA, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_SAMPLE, 10'h3FF, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_INC, 10'h3FF, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_DEC, 10'h000, 1'b0, 1'b0);
        add_item(fefc_pkg::OP_DEC, 10'h155, 1'b0, 1'b0);
        for (n = 0; n < NTAPS; n++) begin
            add_item(fefc_pkg::OP_SELECT, 10'($urandom), 1'b0, 1'b0);
        end
        add_item(fefc_pkg::OP_INC, 10'h2AA, 1'b0, 1'b0);

        // back-to-back edits on the center tap
        for (n = 0; n < 8; n++) begin
            add_item(fefc_pkg::OP_SELECT, 10'($urandom), (n == 0), 1'b1);
        end
        for (n = 0; n < 12; n++) begin
            add_item(fefc_pkg::OP_INC, 10'($urandom), 1'b0, 1'b1);
        end
        for (n = 0; n < 6; n++) begin
            add_item(fefc_pkg::OP_DEC, 10'($urandom), 1'b0, 1'b1);
        end
        add_item(fefc_pkg::OP_SAMPLE, 10'h3FF, 1'b0, 1'b1);

        for (n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(0, 9);
            case (r)
                6: op = fefc_pkg::OP_SELECT;
                7: op = fefc_pkg::OP_INC;
                8: op = fefc_pkg::OP_DEC;
                9: op = ($urandom_range(0, 1) == 0) ? fefc_pkg::OP_INC : fefc_pkg::OP_DEC;
                default: op = fefc_pkg::OP_SAMPLE;
            endcase
            case ($urandom_range(0, 3))
                0: smp = 10'h000;
                1: smp = 10'h3FF;
                default: smp = 10'($urandom);
            endcase
            add_item(op, smp, (n == 0 || n == RAND_ITEMS / 2), 1'b0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);

        $display("sent %0d samples and %0d coefficient edits, %0d results checked",
                 samples_sent, edits_sent, results_checked);
        $display("all operations, index wrap and full-scale samples under stalls, %0d errors",
                 errors);
        if (errors == 0) begin
            $display("fir_filter_editable_coefficients_top test passed");
        end else begin
            $display("fir_filter_editable_coefficients_top test failed");
        end
        $finish;
    end

endmodule
